### hdl/dfr_pkg.sv
package dfr_pkg;

    localparam logic [7:0] MARK_DLE = 8'd11;
    localparam logic [7:0] MARK_STX = 8'd2;
    localparam logic [7:0] CMD_ACK  = 8'd7;
    localparam logic [7:0] CMD_NACK = 8'd8;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] MIN_SIZE = 8'd2;

    typedef enum logic
    {
        KIND_DATA    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        VERD_SEND_ACK     = 3'd0,
        VERD_SEND_NACK    = 3'd1,
        VERD_ACK_MATCHED  = 3'd2,
        VERD_ACK_BAD_SEQ  = 3'd3,
        VERD_NACK_RESEND  = 3'd4,
        VERD_IGNORED      = 3'd5,
        VERD_MALFORMED    = 3'd6
    } verdict_t;

    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] payload_byte;
        verdict_t   verdict;
        logic [7:0] frame_seq;
        logic [7:0] frame_command;
        logic [7:0] frame_target;
    } result_t;

    // crc-8, msb first, one byte folded in
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (r[7])
            begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

### hdl/dfr_rx_if.sv
interface dfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       awaiting_ack;
    logic [7:0] expected_seq;

    modport source (output valid, output rx_byte, output awaiting_ack,
                    output expected_seq, input ready);
    modport sink (input valid, input rx_byte, input awaiting_ack,
                  input expected_seq, output ready);
endinterface

### hdl/dfr_res_if.sv
interface dfr_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] verdict;
    logic [7:0] frame_seq;
    logic [7:0] frame_command;
    logic [7:0] frame_target;

    modport source (output valid, output kind, output payload_byte, output verdict,
                    output frame_seq, output frame_command, output frame_target,
                    input ready);
    modport sink (input valid, input kind, input payload_byte, input verdict,
                  input frame_seq, input frame_command, input frame_target,
                  output ready);
endinterface

### hdl/dfr_parser.sv
module dfr_parser
    import dfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    input  logic       awaiting_ack,
    input  logic [7:0] expected_seq,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [2:0]
    {
        ST_HUNT,
        ST_STX,
        ST_SEQ,
        ST_SIZE,
        ST_CMD,
        ST_TGT,
        ST_DATA,
        ST_CHK
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] seq_reg, seq_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] tgt_reg, tgt_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] crc_upd;
    logic [7:0] left_dec;
    logic [8:0] left_plus2;

    assign crc_upd    = crc8_next(crc_reg, rx_byte);
    assign left_dec   = left_reg - 8'd1;
    assign left_plus2 = {1'b0, left_reg} + 9'd2;

    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        tgt_next   = tgt_reg;
        first_next = first_reg;
        res_valid  = 1'b0;
        res.kind          = KIND_DATA;
        res.payload_byte  = 8'd0;
        res.verdict       = VERD_SEND_ACK;
        res.frame_seq     = seq_reg;
        res.frame_command = cmd_reg;
        res.frame_target  = tgt_reg;

        case (state_reg)
            ST_HUNT:
            begin
                if (rx_byte == MARK_DLE)
                begin
                    state_next = ST_STX;
                end
            end
            ST_STX:
            begin
                if (rx_byte == MARK_STX)
                begin
                    state_next = ST_SEQ;
                end
                else if (rx_byte != MARK_DLE)
                begin
                    state_next = ST_HUNT;
                end
            end
            ST_SEQ:
            begin
                seq_next   = rx_byte;
                state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                size_next = rx_byte;
                if (rx_byte < MIN_SIZE)
                begin
                    state_next        = ST_HUNT;
                    res_valid         = 1'b1;
                    res.kind          = KIND_VERDICT;
                    res.verdict       = VERD_MALFORMED;
                    res.frame_command = 8'd0;
                    res.frame_target  = 8'd0;
                end
                else
                begin
                    left_next  = rx_byte - MIN_SIZE;
                    crc_next   = 8'd0;
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                cmd_next   = rx_byte;
                crc_next   = crc8_next(8'd0, rx_byte) ^ crc8_next(crc_reg, 8'd0);
                state_next = ST_TGT;
            end
            ST_TGT:
            begin
                tgt_next   = rx_byte;
                crc_next   = crc_upd;
                state_next = (left_reg == 8'd0) ? ST_CHK : ST_DATA;
            end
            ST_DATA:
            begin
                if (left_plus2 == {1'b0, size_reg})
                begin
                    first_next = rx_byte;
                end
                crc_next  = crc_upd;
                left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    state_next = ST_CHK;
                end
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
            end
            ST_CHK:
            begin
                if (size_reg == MIN_SIZE)
                begin
                    first_next = rx_byte;
                end
                crc_next   = crc_upd;
                state_next = ST_HUNT;
                res_valid  = 1'b1;
                res.kind   = KIND_VERDICT;
                if (crc_upd != 8'd0)
                begin
                    res.verdict = VERD_SEND_NACK;
                end
                else if (!awaiting_ack)
                begin
                    res.verdict = VERD_SEND_ACK;
                end
                else if (first_next == CMD_ACK)
                begin
                    res.verdict = (seq_reg == expected_seq) ? VERD_ACK_MATCHED
                                                            : VERD_ACK_BAD_SEQ;
                end
                else if (first_next == CMD_NACK)
                begin
                    res.verdict = VERD_NACK_RESEND;
                end
                else
                begin
                    res.verdict = VERD_IGNORED;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase

        if (!fire)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            seq_reg   <= 8'd0;
            size_reg  <= 8'd0;
            left_reg  <= 8'd0;
            crc_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            tgt_reg   <= 8'd0;
            first_reg <= 8'd0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            tgt_reg   <= tgt_next;
            first_reg <= first_next;
        end
    end

endmodule

### hdl/dfr_out_buf.sv
module dfr_out_buf
    import dfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    head_valid,
    output result_t head,
    input  logic    pop_ready
);

    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = head_valid_reg && pop_ready;
    assign space      = !skid_valid_reg;
    assign head_valid = head_valid_reg;
    assign head       = head_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                // skid moves up; no push possible while skid is full
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                head_next = push_data;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

### hdl/dle_frame_receiver_crc8.sv
// dle/stx frame receiver with crc-8 check and ack/nack verdict
//
// rx channel: one received serial byte per item, with awaiting_ack and
//   expected_seq sampled alongside (they only matter on the crc byte)
// res channel: zero or one item per rx item; kind 0 carries a data byte
//   of the frame, kind 1 carries the end-of-frame verdict (or a malformed
//   verdict, with zero command and target, when the size byte is below
//   two), with the frame's sequence, command and target bytes attached
// results: each result is registered into the head or skid register
// throughput: one rx item per cycle while the skid slot is free; parser
//   state and crc-8 are a single shallow step per byte, so nothing iterates
// reset: parser goes back to hunting for dle, all held bytes and the crc
//   clear, and the two-entry result buffer empties
// stall: results sit in a head register plus a skid register; rx stays
//   ready as long as the skid register is free, so one stalled result does
//   not hold up the link, a second pending result deasserts rx.ready
module dle_frame_receiver_crc8
    import dfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dfr_rx_if.sink    rx,
    dfr_res_if.source res
);

    logic    fire;
    logic    space;
    logic    res_valid;
    result_t parsed;
    logic    head_valid;
    result_t head;

    // ready comes from a register only: the skid slot being free
    assign rx.ready = space;
    assign fire     = rx.valid && space;

    // byte parser, crc and verdict logic
    dfr_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .rx_byte      (rx.rx_byte),
        .awaiting_ack (rx.awaiting_ack),
        .expected_seq (rx.expected_seq),
        .res_valid    (res_valid),
        .res          (parsed)
    );

    // result register with skid stage
    dfr_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (parsed),
        .space      (space),
        .head_valid (head_valid),
        .head       (head),
        .pop_ready  (res.ready)
    );

    assign res.valid         = head_valid;
    assign res.kind          = head.kind;
    assign res.payload_byte  = head.payload_byte;
    assign res.verdict       = head.verdict;
    assign res.frame_seq     = head.frame_seq;
    assign res.frame_command = head.frame_command;
    assign res.frame_target  = head.frame_target;

endmodule
